### hdl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants of the pixel pair interpolator: payload structs
// for both channels and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package ppi_pkg;

   localparam int CH_W     = 8;   // bits per color channel
   localparam int NUM_CH   = 3;   // blue, green, red
   localparam int FACTOR_W = 5;   // zoom factor register width

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;

   typedef struct packed {
      logic [CH_W-1:0] first_blue;
      logic [CH_W-1:0] first_green;
      logic [CH_W-1:0] first_red;
      logic [CH_W-1:0] second_blue;
      logic [CH_W-1:0] second_green;
      logic [CH_W-1:0] second_red;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] out_blue;
      logic [CH_W-1:0] out_green;
      logic [CH_W-1:0] out_red;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic                load;     // capture pixel pair, seed dividers
      logic                iterate;  // one restoring division step
      logic                emit;     // produce one in-between pixel
      logic                last;     // pixel being emitted closes the pair
      logic [FACTOR_W-1:0] divisor;
   } cmd_type;

endpackage

### hdl/pixel_pair_interpolator.sv
// ----------------------------------------------------------------------------
// pixel_pair_interpolator
// Emits the zoom_factor-1 linearly interpolated BGR pixels between two
// neighboring pixels, ordered from the first toward the second.
// ----------------------------------------------------------------------------
// A pair is taken when start is high and busy is low. Busy then stays high
// through the per-channel division (one quotient bit per cycle, all three
// channels in parallel) and while the in-between pixels are emitted, one per
// cycle, so a new pair is taken only once the last one has been emitted. Each
// pixel shows on rsp_data with rsp_strobe, registered from the step that
// emits it; the first follows division, the rest follow on consecutive
// cycles, the final one flagged by last. Each strobe lasts one cycle and
// cannot be held off, so the receiver must take every item as it comes.
// A factor of 0 or 1 produces no items. Factors above MAX_FACTOR act as
// MAX_FACTOR. Write zoom_factor on the csr port only while the block is idle.
// ----------------------------------------------------------------------------
module pixel_pair_interpolator
   import ppi_pkg::*;
#(
   parameter int MAX_FACTOR = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_strobe,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FACTOR_W-1:0] csr_data
);

   localparam int FACTOR_MAX = (1 << FACTOR_W) - 1;
   localparam int KMAX       = (MAX_FACTOR < FACTOR_MAX) ? MAX_FACTOR : FACTOR_MAX;
   localparam int POS_W      = $clog2(KMAX);

   cmd_type          cmd;
   logic [POS_W-1:0] pos_up;
   logic [POS_W-1:0] pos_down;

   ppi_controller #(
      .MAX_FACTOR (MAX_FACTOR),
      .POS_W      (POS_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .pos_up    (pos_up),
      .pos_down  (pos_down)
   );

   ppi_datapath #(
      .POS_W (POS_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .pos_up     (pos_up),
      .pos_down   (pos_down),
      .req_data   (req_data),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

### hdl/ppi_div_lane.sv
// ----------------------------------------------------------------------------
// ppi_div_lane
// Restoring divider for one color channel: one quotient bit per iterate
// strobe, CH_W strobes for a full quotient.
// ----------------------------------------------------------------------------
module ppi_div_lane
   import ppi_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  logic                iterate,
   input  logic [CH_W-1:0]     dividend,
   input  logic [FACTOR_W-1:0] divisor,
   output logic [CH_W-1:0]     quotient
);

   logic [CH_W-1:0]     quo_ff, quo_in;
   logic [FACTOR_W-1:0] rem_ff, rem_in;
   logic [FACTOR_W:0]   trial;
   logic [FACTOR_W:0]   trial_sub;
   logic                fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[CH_W-1]};
      trial_sub = trial - {1'b0, divisor};
      fits      = (trial >= {1'b0, divisor});
      // restore when the divisor does not fit
      rem_in    = fits ? trial_sub[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
      quo_in    = {quo_ff[CH_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (iterate) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;

endmodule

### hdl/ppi_datapath.sv
// ----------------------------------------------------------------------------
// ppi_datapath
// Per-channel base, direction and step registers, three division lanes and
// the output register that forms each in-between pixel as base + pos*step.
// ----------------------------------------------------------------------------
module ppi_datapath
   import ppi_pkg::*;
#(
   parameter int POS_W = 4
)
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [POS_W-1:0] pos_up,
   input  logic [POS_W-1:0] pos_down,
   input  req_type          req_data,
   output rsp_type          rsp_data,
   output logic             rsp_strobe
);

   logic [CH_W-1:0] first_ch  [NUM_CH];
   logic [CH_W-1:0] second_ch [NUM_CH];
   logic [CH_W-1:0] value     [NUM_CH];

   rsp_type rsp_ff, rsp_in;
   logic    strobe_ff;

   assign first_ch[0]  = req_data.first_blue;
   assign first_ch[1]  = req_data.first_green;
   assign first_ch[2]  = req_data.first_red;
   assign second_ch[0] = req_data.second_blue;
   assign second_ch[1] = req_data.second_green;
   assign second_ch[2] = req_data.second_red;

   for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      logic                  first_gt;
      logic [CH_W-1:0]       diff;
      logic [CH_W-1:0]       base_ff;
      logic                  desc_ff;
      logic [CH_W-1:0]       step;
      logic [POS_W-1:0]      pos_sel;
      logic [POS_W+CH_W-1:0] prod;

      assign first_gt = (first_ch[c] > second_ch[c]);
      assign diff     = first_gt ? (first_ch[c] - second_ch[c])
                                 : (second_ch[c] - first_ch[c]);

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            base_ff <= first_gt ? second_ch[c] : first_ch[c];
            desc_ff <= first_gt;
         end
      end

      ppi_div_lane u_div (
         .clock    (clock),
         .load     (cmd.load),
         .iterate  (cmd.iterate),
         .dividend (diff),
         .divisor  (cmd.divisor),
         .quotient (step)
      );

      // descending channels walk down from the far end
      assign pos_sel  = desc_ff ? pos_down : pos_up;
      assign prod     = pos_sel * step;
      assign value[c] = base_ff + prod[CH_W-1:0];
   end

   always_comb begin
      rsp_in.out_blue  = value[0];
      rsp_in.out_green = value[1];
      rsp_in.out_red   = value[2];
      rsp_in.last      = cmd.last;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

### hdl/ppi_controller.sv
// ----------------------------------------------------------------------------
// ppi_controller
// Zoom factor register and the sequencer: capture a pair, run the division
// steps, then count out the in-between pixels.
// ----------------------------------------------------------------------------
module ppi_controller
   import ppi_pkg::*;
#(
   parameter int MAX_FACTOR = 16,
   parameter int POS_W      = 4
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FACTOR_W-1:0] csr_data,
   output cmd_type             cmd,
   output logic [POS_W-1:0]    pos_up,
   output logic [POS_W-1:0]    pos_down
);

   localparam int FACTOR_MAX = (1 << FACTOR_W) - 1;
   localparam int KMAX       = (MAX_FACTOR < FACTOR_MAX) ? MAX_FACTOR : FACTOR_MAX;
   localparam int IW         = $clog2(CH_W);
   localparam logic [IW-1:0]       ITER_LAST = IW'(CH_W - 1);
   localparam logic [FACTOR_W-1:0] K_LIMIT   = FACTOR_W'(KMAX);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [FACTOR_W-1:0] factor_ff;
   logic [IW-1:0]       iter_ff, iter_in;
   logic [FACTOR_W-1:0] div_ff, div_in;
   logic [POS_W-1:0]    up_ff, up_in;
   logic [POS_W-1:0]    down_ff, down_in;
   logic [FACTOR_W-1:0] k_clamped;
   logic [FACTOR_W-1:0] div_sel;
   logic [POS_W-1:0]    count_sel;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else if (csr_valid && csr_ready) begin
         factor_ff <= csr_data;
      end
   end

   always_comb begin
      k_clamped = (factor_ff > K_LIMIT) ? K_LIMIT : factor_ff;
      // a factor of zero divides by one and emits nothing
      div_sel   = (k_clamped == '0) ? FACTOR_W'(1) : k_clamped;
      count_sel = (k_clamped > FACTOR_W'(1)) ? POS_W'(k_clamped - FACTOR_W'(1)) : '0;
   end

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      div_in      = div_ff;
      up_in       = up_ff;
      down_in     = down_ff;
      cmd.load    = 1'b0;
      cmd.iterate = 1'b0;
      cmd.emit    = 1'b0;
      cmd.last    = 1'b0;
      cmd.divisor = div_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
               iter_in  = '0;
               div_in   = div_sel;
               up_in    = POS_W'(1);
               down_in  = count_sel;
            end
         end
         ST_DIVIDE: begin
            cmd.iterate = 1'b1;
            iter_in     = iter_ff + IW'(1);
            if (iter_ff == ITER_LAST) begin
               state_in = (down_ff == '0) ? ST_IDLE : ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.last = (down_ff == POS_W'(1));
            up_in    = up_ff + POS_W'(1);
            down_in  = down_ff - POS_W'(1);
            if (cmd.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         div_ff   <= FACTOR_W'(1);
         up_ff    <= '0;
         down_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         div_ff   <= div_in;
         up_ff    <= up_in;
         down_ff  <= down_in;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign pos_up   = up_ff;
   assign pos_down = down_ff;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel pair interpolator. A queue of pixel pairs
// and zoom factor writes feeds a clocked driver with random idle bursts. Each
// accepted pair is run through a local predictor that produces the expected
// in-between pixels. A clocked monitor checks every strobed pixel against the
// oldest expected one. Factor writes wait until the block has drained.
// ----------------------------------------------------------------------------
module tb;
   import ppi_pkg::*;

   localparam int MAX_FACTOR   = 16;
   localparam int DRAIN_CYCLES = 32;    // idle wait before each factor write and at the end
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_PAIRS = 380;
   localparam int CALM_TAIL    = 50;

   typedef enum logic {
      WORK_PAIR,
      WORK_FACTOR
   } work_kind_type;

   typedef struct {
      work_kind_type       kind;
      req_type             pair;
      logic [FACTOR_W-1:0] factor;
      logic                calm;
   } work_entry_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   logic                busy;
   req_type             req_data   = '0;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [FACTOR_W-1:0] csr_data   = '0;

   work_entry_type      work_q[$];
   rsp_type             pixel_q[$];

   logic [FACTOR_W-1:0] factor_reg = FACTOR_RESET;
   logic [CH_W-1:0]     chan_step [NUM_CH];
   logic [CH_W-1:0]     chan_base [NUM_CH];
   logic                chan_desc [NUM_CH];

   int                  error_count = 0;
   int                  gap_left    = 0;
   int                  settle_left = DRAIN_CYCLES;
   int                  idle_cycles = 0;
   logic                pair_taken;
   logic                factor_taken;
   logic                nxt_start;
   logic                nxt_csr_valid;

   pixel_pair_interpolator #(
      .MAX_FACTOR (MAX_FACTOR)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   task automatic flag_error(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   // Work out the in-between pixels of one pair at the current factor.
   task automatic predict_pixels(input req_type pair);
      logic [CH_W-1:0] first_v  [NUM_CH];
      logic [CH_W-1:0] second_v [NUM_CH];
      logic [CH_W-1:0] lo;
      logic [CH_W-1:0] hi;
      logic [CH_W-1:0] level [NUM_CH];
      int unsigned     k;
      int unsigned     divisor;
      int unsigned     count;
      int unsigned     pos;
      rsp_type         px;
      first_v  = '{pair.first_blue, pair.first_green, pair.first_red};
      second_v = '{pair.second_blue, pair.second_green, pair.second_red};
      k = 32'(factor_reg);
      if (k > MAX_FACTOR) begin
         k = MAX_FACTOR;
      end
      divisor = (k < 1) ? 1 : k;
      count   = (k > 1) ? k - 1 : 0;
      for (int c = 0; c < NUM_CH; c++) begin
         lo = (first_v[c] > second_v[c]) ? second_v[c] : first_v[c];
         hi = (first_v[c] > second_v[c]) ? first_v[c] : second_v[c];
         chan_step[c] = CH_W'((hi - lo) / divisor);
         chan_base[c] = lo;
         chan_desc[c] = first_v[c] > second_v[c];
      end
      for (int unsigned i = 0; i < count; i++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            pos = chan_desc[c] ? count - i : i + 1;
            level[c] = CH_W'(chan_base[c] + pos * chan_step[c]);
         end
         px.out_blue  = level[0];
         px.out_green = level[1];
         px.out_red   = level[2];
         px.last      = (i + 1 == count);
         pixel_q.push_back(px);
      end
   endtask

   function automatic logic [CH_W-1:0] pick_level();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         return '0;
      end else if (roll == 1) begin
         return '1;
      end
      return CH_W'($urandom_range(0, 255));
   endfunction

   task automatic queue_pair(input logic [CH_W-1:0] fb, input logic [CH_W-1:0] fg,
                             input logic [CH_W-1:0] fr, input logic [CH_W-1:0] sb,
                             input logic [CH_W-1:0] sg, input logic [CH_W-1:0] sr,
                             input logic calm);
      work_entry_type w;
      w.kind   = WORK_PAIR;
      w.pair   = '{fb, fg, fr, sb, sg, sr};
      w.factor = '0;
      w.calm   = calm;
      work_q.push_back(w);
   endtask

   task automatic queue_factor(input logic [FACTOR_W-1:0] value);
      work_entry_type w;
      w.kind   = WORK_FACTOR;
      w.pair   = '0;
      w.factor = value;
      w.calm   = 1'b1;
      work_q.push_back(w);
   endtask

   task automatic queue_random_pair(input logic calm);
      logic [CH_W-1:0] f [NUM_CH];
      logic [CH_W-1:0] s [NUM_CH];
      for (int c = 0; c < NUM_CH; c++) begin
         f[c] = pick_level();
         s[c] = ($urandom_range(0, 5) == 0) ? f[c] : pick_level();
      end
      queue_pair(f[0], f[1], f[2], s[0], s[1], s[2], calm);
   endtask

   // Driver: one pending item at a time, factor writes only once drained.
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         pair_taken   = start && !busy;
         factor_taken = csr_valid && csr_ready;
         if (pair_taken) begin
            predict_pixels(req_data);
         end
         if (factor_taken) begin
            factor_reg = csr_data;
         end
         nxt_start     = start && !pair_taken;
         nxt_csr_valid = csr_valid && !factor_taken;
         if (!nxt_start && !nxt_csr_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (work_q.size() != 0) begin
               if (work_q[0].kind == WORK_FACTOR) begin
                  if (pixel_q.size() != 0 || busy) begin
                     settle_left = DRAIN_CYCLES;
                  end else if (settle_left != 0) begin
                     settle_left--;
                  end else begin
                     nxt_csr_valid = 1'b1;
                     csr_data     <= work_q[0].factor;
                     settle_left   = DRAIN_CYCLES;
                     void'(work_q.pop_front());
                  end
               end else if (!work_q[0].calm && $urandom_range(0, 4) == 0) begin
                  gap_left = $urandom_range(1, 8) - 1;
               end else begin
                  nxt_start = 1'b1;
                  req_data <= work_q[0].pair;
                  void'(work_q.pop_front());
               end
            end
         end
         start     <= nxt_start;
         csr_valid <= nxt_csr_valid;
      end
   end

   // Monitor: every strobe must match the oldest expected pixel.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pixel_q.size() == 0) begin
            flag_error($sformatf("unexpected pixel %h", rsp_data));
         end else begin
            want = pixel_q.pop_front();
            if (rsp_data.out_blue !== want.out_blue)
               flag_error($sformatf("out_blue %0d, expected %0d",
                                    rsp_data.out_blue, want.out_blue));
            if (rsp_data.out_green !== want.out_green)
               flag_error($sformatf("out_green %0d, expected %0d",
                                    rsp_data.out_green, want.out_green));
            if (rsp_data.out_red !== want.out_red)
               flag_error($sformatf("out_red %0d, expected %0d",
                                    rsp_data.out_red, want.out_red));
            if (rsp_data.last !== want.last)
               flag_error($sformatf("last %0b, expected %0b",
                                    rsp_data.last, want.last));
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no activity for %0d cycles", STALL_LIMIT);
         $display("pixel_pair_interpolator verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned phase_factor;
      int unsigned phase_len;
      int          sent;
      logic        phase_calm;

      // reset factor of 2: flat, full swing both ways, mixed directions
      queue_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      queue_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
      queue_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
      queue_pair(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128, 1'b1);
      // largest factor, most pixels per pair
      queue_factor(5'd16);
      queue_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
      queue_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
      queue_pair(8'd10, 8'd200, 8'd77, 8'd250, 8'd3, 8'd77, 1'b0);
      queue_pair(8'd0, 8'd15, 8'd255, 8'd15, 8'd0, 8'd240, 1'b1);
      // factors above the maximum saturate
      queue_factor(5'd31);
      queue_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
      queue_pair(8'd200, 8'd100, 8'd1, 8'd100, 8'd200, 8'd254, 1'b0);
      queue_factor(5'd17);
      queue_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
      // factors of zero and one emit nothing but still take the pair
      queue_factor(5'd0);
      queue_pair(8'd1, 8'd2, 8'd3, 8'd200, 8'd100, 8'd50, 1'b0);
      queue_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
      queue_factor(5'd1);
      queue_pair(8'd0, 8'd128, 8'd255, 8'd255, 8'd128, 8'd0, 1'b0);
      queue_pair(8'd9, 8'd9, 8'd9, 8'd90, 8'd90, 8'd90, 1'b1);
      queue_factor(5'd3);
      queue_pair(8'd0, 8'd255, 8'd100, 8'd255, 8'd0, 8'd102, 1'b0);
      queue_pair(8'd7, 8'd8, 8'd250, 8'd6, 8'd8, 8'd0, 1'b1);

      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         case ($urandom_range(0, 7))
            0: begin
               phase_factor = $urandom_range(0, 1);
            end
            1: begin
               phase_factor = $urandom_range(17, 31);
            end
            default: begin
               phase_factor = $urandom_range(2, 16);
            end
         endcase
         phase_len  = $urandom_range(15, 35);
         phase_calm = ($urandom_range(0, 2) == 0);
         queue_factor(FACTOR_W'(phase_factor));
         for (int unsigned n = 0; n < phase_len && sent < RANDOM_PAIRS; n++) begin
            queue_random_pair(phase_calm || sent >= RANDOM_PAIRS - CALM_TAIL);
            sent++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (work_q.size() != 0 || start || csr_valid || pixel_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES + 8) @(posedge clock);
      if (error_count == 0 && pixel_q.size() == 0) begin
         $display("pixel_pair_interpolator verification clean");
      end else begin
         $display("pixel_pair_interpolator verification failed");
      end
      $finish;
   end

endmodule
